FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the frame buffer pool allocator RTL.
// Each macro expands to one labeled concurrent assertion clocked on clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/fbpa_pkg.sv
// Package for the frame buffer pool allocator: request and usage codes,
// sequencer states, tiers and the structs passed between modules. No dependencies.
`timescale 1ns / 1ps

package fbpa_pkg;

    // Default pool storage size and the largest active count the register allows.
    localparam int NUM_ENTRIES_DEF = 8;
    localparam int MAX_ACTIVE      = 8;

    // Field widths fixed by the interface.
    localparam int TAG_W  = 16;
    localparam int CNT_W  = 4;

    // Request kinds carried in tuser; code 3 means nothing.
    typedef enum logic [1:0] {
        REQ_GET  = 2'd0,
        REQ_PUT  = 2'd1,
        REQ_MARK = 2'd2
    } req_t;

    // Per-entry usage state.
    typedef enum logic [1:0] {
        USE_FREE = 2'd0,
        USE_CUR  = 2'd1,
        USE_PREP = 2'd2
    } usage_t;

    // Grant tiers reported with each get.
    typedef enum logic [1:0] {
        TIER_MATCH  = 2'd0,
        TIER_BLANK  = 2'd1,
        TIER_ANY    = 2'd2,
        TIER_FORCED = 2'd3
    } tier_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_APPLY,
        ST_DONE
    } state_t;

    // Result of comparing one pool entry against a get request.
    typedef struct packed {
        logic is_free;
        logic tag_hit;
        logic blank;
    } cmp_flags_t;

    // Write controls into the pool store.
    typedef struct packed {
        logic   set_tag;
        logic   set_usage;
        logic   set_holds;
        usage_t usage_val;
        logic   holds_val;
    } pool_wr_t;

endpackage

FILE: rtl/core/frame_buffer_pool_allocator.sv
// Frame buffer pool allocator: one request in, one result out. A single compare
// unit walks the N active entries one per cycle (N is extra_buffers + 1, at most
// the pool size). A get passes through ST_SCAN and ST_DECIDE before m_tvalid
// rises, a put or mark through ST_APPLY, and m_tvalid rises in the cycle right
// after the transfer in of an unknown request. The block takes a new request
// only in ST_IDLE, entered once the previous result has been transferred out.
// Writing extra_buffers clears the whole pool at once.
// Depends on fbpa_pkg, fbpa_entry_cmp, fbpa_pool_store and assert_macros.svh.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module frame_buffer_pool_allocator #(
    parameter int NUM_ENTRIES = fbpa_pkg::NUM_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Request stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] image_tag, [16] urgent, [19:17] entry_index, [20] filled_value
    input  logic [23:0] s_tdata,
    // [1:0] req_type
    input  logic [1:0]  s_tuser,
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] granted, [3:1] granted_entry, [4] is_device_buffer,
    // [6:5] grant_tier, [7] entry_filled
    output logic [7:0]  m_tdata,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fbpa_pkg::*;

    localparam int DEPTH = (NUM_ENTRIES < MAX_ACTIVE) ? NUM_ENTRIES : MAX_ACTIVE;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Configuration register.
    logic [2:0] extra_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {29'd0, extra_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            extra_reg <= 3'd7;
        end
        else if (cfg_wr)
        begin
            extra_reg <= pwdata[2:0];
        end
    end

    // Active entry count and device buffer position.
    logic [CNT_W-1:0] ext_cnt;
    logic [CNT_W-1:0] act_cnt;
    logic [CNT_W-1:0] dev_pos;

    assign ext_cnt = {1'b0, extra_reg} + 4'd1;
    assign act_cnt = (ext_cnt > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : ext_cnt;
    assign dev_pos = act_cnt - 4'd1;

    // Latched request.
    logic [1:0]       req_reg;
    logic [TAG_W-1:0] tag_reg;
    logic             urg_reg;
    logic [2:0]       idx_reg;
    logic             fv_reg;

    // Scan counter and first-found candidates of each tier.
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             f0_reg, f0_next;
    logic [IDX_W-1:0] f0_idx_reg, f0_idx_next;
    logic             f0_fill_reg, f0_fill_next;
    logic             f1_reg, f1_next;
    logic [IDX_W-1:0] f1_idx_reg, f1_idx_next;
    logic             f2_reg, f2_next;
    logic [IDX_W-1:0] f2_idx_reg, f2_idx_next;

    // Result register.
    logic [7:0] res_reg, res_next;
    logic       res_load;

    state_t state_reg, state_next;

    logic accept;
    logic scan_last;
    logic idx_active;

    assign accept     = s_tvalid && s_tready;
    assign scan_last  = (CNT_W'(cnt_reg) == dev_pos);
    assign idx_active = ({1'b0, idx_reg} < act_cnt);

    // Pool store and compare unit.
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] wr_idx;
    usage_t           rd_usage;
    logic [TAG_W-1:0] rd_tag;
    logic             rd_holds;
    pool_wr_t         wr;
    cmp_flags_t       flags;

    assign rd_idx = (state_reg == ST_SCAN) ? cnt_reg : idx_reg[IDX_W-1:0];

    fbpa_pool_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .init     (cfg_wr),
        .init_cur (pwdata[2:0] == 3'd0),
        .rd_idx   (rd_idx),
        .rd_usage (rd_usage),
        .rd_tag   (rd_tag),
        .rd_holds (rd_holds),
        .wr_idx   (wr_idx),
        .wr       (wr),
        .wr_tag   (tag_reg)
    );

    fbpa_entry_cmp u_cmp (
        .entry_usage (rd_usage),
        .entry_tag   (rd_tag),
        .entry_holds (rd_holds),
        .want_tag    (tag_reg),
        .flags       (flags)
    );

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == REQ_GET)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (s_tuser == REQ_PUT || s_tuser == REQ_MARK)
                    begin
                        state_next = ST_APPLY;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = ST_DONE;
            end
            ST_APPLY:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output and datapath control for each state.
    always_comb
    begin
        cnt_next     = cnt_reg;
        f0_next      = f0_reg;
        f0_idx_next  = f0_idx_reg;
        f0_fill_next = f0_fill_reg;
        f1_next      = f1_reg;
        f1_idx_next  = f1_idx_reg;
        f2_next      = f2_reg;
        f2_idx_next  = f2_idx_reg;
        res_next     = res_reg;
        res_load     = 1'b0;
        wr           = '0;
        wr.usage_val = USE_FREE;
        wr_idx       = idx_reg[IDX_W-1:0];
        s_tready     = 1'b0;
        m_tvalid     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cnt_next = '0;
                f0_next  = 1'b0;
                f1_next  = 1'b0;
                f2_next  = 1'b0;
                // An unknown request answers all zero right away.
                res_next = 8'd0;
                res_load = 1'b1;
            end
            ST_SCAN:
            begin
                // Keep the first hit of each tier as the walk goes up.
                if (flags.is_free && flags.tag_hit && !f0_reg)
                begin
                    f0_next      = 1'b1;
                    f0_idx_next  = cnt_reg;
                    f0_fill_next = ~flags.blank;
                end
                if (flags.is_free && flags.blank && !f1_reg)
                begin
                    f1_next     = 1'b1;
                    f1_idx_next = cnt_reg;
                end
                if (flags.is_free && !f2_reg)
                begin
                    f2_next     = 1'b1;
                    f2_idx_next = cnt_reg;
                end
                cnt_next = cnt_reg + 1'b1;
            end
            ST_DECIDE:
            begin
                res_load         = 1'b1;
                res_next         = 8'd0;
                wr.set_tag       = 1'b1;
                wr.set_usage     = 1'b1;
                wr.usage_val     = urg_reg ? USE_CUR : USE_PREP;
                if (f0_reg)
                begin
                    wr_idx       = f0_idx_reg;
                    res_next[6:5] = TIER_MATCH;
                    res_next[7]   = f0_fill_reg;
                end
                else if (f1_reg)
                begin
                    wr_idx        = f1_idx_reg;
                    res_next[6:5] = TIER_BLANK;
                end
                else if (f2_reg)
                begin
                    wr_idx        = f2_idx_reg;
                    wr.set_holds  = 1'b1;
                    res_next[6:5] = TIER_ANY;
                end
                else
                begin
                    // Nothing free: take entry 0 by force when urgent.
                    wr_idx        = '0;
                    wr.set_holds  = urg_reg;
                    wr.set_tag    = urg_reg;
                    wr.set_usage  = urg_reg;
                    res_next[6:5] = urg_reg ? TIER_FORCED : TIER_MATCH;
                end
                wr.holds_val = 1'b0;
                if (f0_reg || f1_reg || f2_reg || urg_reg)
                begin
                    res_next[0]   = 1'b1;
                    res_next[3:1] = 3'(wr_idx);
                    res_next[4]   = (CNT_W'(wr_idx) == dev_pos);
                end
            end
            ST_APPLY:
            begin
                res_load      = 1'b1;
                res_next      = 8'd0;
                res_next[3:1] = idx_reg;
                if (idx_active)
                begin
                    res_next[0] = 1'b1;
                    res_next[4] = ({1'b0, idx_reg} == dev_pos);
                    if (req_reg == REQ_PUT)
                    begin
                        wr.set_usage = 1'b1;
                        wr.usage_val = USE_FREE;
                        res_next[7]  = rd_holds;
                    end
                    else
                    begin
                        wr.set_holds = 1'b1;
                        wr.holds_val = fv_reg;
                        res_next[7]  = fv_reg;
                    end
                end
            end
            ST_DONE:
            begin
                m_tvalid = 1'b1;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            f0_reg    <= 1'b0;
            f1_reg    <= 1'b0;
            f2_reg    <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            f0_reg    <= f0_next;
            f1_reg    <= f1_next;
            f2_reg    <= f2_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= s_tuser;
            tag_reg <= s_tdata[15:0];
            urg_reg <= s_tdata[16];
            idx_reg <= s_tdata[19:17];
            fv_reg  <= s_tdata[20];
        end
        if (res_load)
        begin
            res_reg <= res_next;
        end
        f0_idx_reg  <= f0_idx_next;
        f0_fill_reg <= f0_fill_next;
        f1_idx_reg  <= f1_idx_next;
        f2_idx_reg  <= f2_idx_next;
    end

    assign m_tdata = res_reg;

    // Checks on the sequencing and the result encoding.
    `ASSERT_IMPLIES(a_one_at_a_time, clk, rst_n, m_tvalid, !s_tready,
                    "input taken while result pending")
    `ASSERT_NEXT(a_busy_after_take, clk, rst_n, s_tvalid && s_tready, !s_tready,
                 "ready right after transfer")
    `ASSERT_IMPLIES(a_refused_clean, clk, rst_n, m_tvalid && !m_tdata[0],
                    m_tdata[7:4] == 4'd0, "refused result not clean")
    `ASSERT_IMPLIES(a_forced_urgent, clk, rst_n, m_tvalid && m_tdata[6:5] == TIER_FORCED,
                    urg_reg && m_tdata[3:1] == 3'd0, "forced grant without urgency")

endmodule

FILE: rtl/core/fbpa_entry_cmp.sv
// Shared compare unit of the allocator: checks one pool entry per cycle
// against the wanted tag. Depends on fbpa_pkg.
`timescale 1ns / 1ps

module fbpa_entry_cmp (
    input  fbpa_pkg::usage_t     entry_usage,
    input  logic [15:0]          entry_tag,
    input  logic                 entry_holds,
    input  logic [15:0]          want_tag,
    output fbpa_pkg::cmp_flags_t flags
);
    import fbpa_pkg::*;

    // One tag compare plus the free and blank tests.
    always_comb
    begin
        flags.is_free = (entry_usage == USE_FREE);
        flags.tag_hit = (entry_tag == want_tag);
        flags.blank   = ~entry_holds;
    end

endmodule

FILE: rtl/core/fbpa_pool_store.sv
// Pool entry store: tag, usage and filled flag per entry, one read port and
// one write port, cleared by reset or by a reinitialize pulse. Depends on fbpa_pkg.
`timescale 1ns / 1ps

module fbpa_pool_store #(
    parameter int DEPTH = fbpa_pkg::NUM_ENTRIES_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         init,
    input  logic                                         init_cur,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_idx,
    output fbpa_pkg::usage_t                             rd_usage,
    output logic [15:0]                                  rd_tag,
    output logic                                         rd_holds,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_idx,
    input  fbpa_pkg::pool_wr_t                           wr,
    input  logic [15:0]                                  wr_tag
);
    import fbpa_pkg::*;

    logic [TAG_W-1:0] tag_reg   [DEPTH];
    usage_t           usage_reg [DEPTH];
    logic             holds_reg [DEPTH];

    // Entry storage; reset and reinitialize clear every entry at once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                tag_reg[i]   <= '0;
                usage_reg[i] <= USE_FREE;
                holds_reg[i] <= 1'b0;
            end
        end
        else if (init)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                tag_reg[i]   <= '0;
                usage_reg[i] <= USE_FREE;
                holds_reg[i] <= 1'b0;
            end
            // A pool with only the device buffer starts with it in current use.
            if (init_cur)
            begin
                usage_reg[0] <= USE_CUR;
            end
        end
        else
        begin
            if (wr.set_tag)
            begin
                tag_reg[wr_idx] <= wr_tag;
            end
            if (wr.set_usage)
            begin
                usage_reg[wr_idx] <= wr.usage_val;
            end
            if (wr.set_holds)
            begin
                holds_reg[wr_idx] <= wr.holds_val;
            end
        end
    end

    // Single read port.
    assign rd_usage = usage_reg[rd_idx];
    assign rd_tag   = tag_reg[rd_idx];
    assign rd_holds = holds_reg[rd_idx];

endmodule

FILE: sim/tb_frame_buffer_pool_allocator.sv
// Self-checking testbench for frame_buffer_pool_allocator: random and directed requests
// are checked against a behavioral model of the pool, with random stalls on both streams.
// Depends on fbpa_pkg and the frame_buffer_pool_allocator RTL.
`timescale 1ns / 1ps

module tb_frame_buffer_pool_allocator;

    import fbpa_pkg::*;

    localparam int POOL_DEPTH      = NUM_ENTRIES_DEF;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int PHASE_ITEMS     = 100;
    localparam int NUM_PHASES      = 8;

    // Request code that the block treats as no operation.
    localparam logic [1:0] REQ_NONE = 2'd3;
    // Byte address of the extra_buffers register.
    localparam logic [2:0] ADDR_EXTRA_BUFFERS = 3'd0;

    // One request as it travels on the input stream.
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] tag;
        logic        urgent;
        logic [2:0]  idx;
        logic        fill;
    } pool_req_t;

    // One result as it travels on the output stream.
    typedef struct packed {
        logic       granted;
        logic [2:0] entry;
        logic       is_dev;
        tier_t      tier;
        logic       filled;
    } grant_t;

    // Pool model: predicts each grant when a request is accepted and
    // holds the predictions until the matching results come out.
    class alloc_checker;
        int unsigned extra_bufs;
        logic [15:0] tag_mem [POOL_DEPTH];
        usage_t      use_mem [POOL_DEPTH];
        logic        holds_mem [POOL_DEPTH];
        grant_t      expected_grants [$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
            extra_bufs = 7;
            clear_pool();
        endfunction

        function void clear_pool();
            for (int i = 0; i < POOL_DEPTH; i++)
            begin
                tag_mem[i]   = '0;
                use_mem[i]   = USE_FREE;
                holds_mem[i] = 1'b0;
            end
            // With no extra buffers the device buffer starts in use.
            if (extra_bufs == 0)
                use_mem[0] = USE_CUR;
        endfunction

        function void configure(int unsigned value);
            extra_bufs = value & 7;
            clear_pool();
        endfunction

        function int active_entries();
            return (extra_bufs + 1 > POOL_DEPTH) ? POOL_DEPTH : extra_bufs + 1;
        endfunction

        // Apply one request to the pool and return the grant it yields.
        function grant_t predict_grant(pool_req_t r);
            grant_t g;
            int     n;
            int     sel;
            tier_t  tier;
            g    = '0;
            n    = active_entries();
            sel  = -1;
            tier = TIER_MATCH;
            case (r.kind)
                REQ_GET:
                begin
                    // Search order: tag match, then blank free, then any free.
                    for (int i = 0; i < n; i++)
                        if (sel < 0 && use_mem[i] == USE_FREE && tag_mem[i] == r.tag)
                        begin
                            sel  = i;
                            tier = TIER_MATCH;
                        end
                    for (int i = 0; i < n; i++)
                        if (sel < 0 && use_mem[i] == USE_FREE && !holds_mem[i])
                        begin
                            sel  = i;
                            tier = TIER_BLANK;
                        end
                    for (int i = 0; i < n; i++)
                        if (sel < 0 && use_mem[i] == USE_FREE)
                        begin
                            sel  = i;
                            tier = TIER_ANY;
                        end
                    // An urgent request takes entry 0 when nothing is free.
                    if (sel < 0 && r.urgent)
                    begin
                        sel  = 0;
                        tier = TIER_FORCED;
                    end
                    if (sel >= 0)
                    begin
                        tag_mem[sel] = r.tag;
                        if (tier == TIER_ANY || tier == TIER_FORCED)
                            holds_mem[sel] = 1'b0;
                        use_mem[sel] = r.urgent ? USE_CUR : USE_PREP;
                        g.granted = 1'b1;
                        g.entry   = 3'(sel);
                        g.is_dev  = (sel == n - 1);
                        g.tier    = tier;
                        g.filled  = holds_mem[sel];
                    end
                end
                REQ_PUT, REQ_MARK:
                begin
                    g.entry = r.idx;
                    // Inactive entries are echoed back without a grant.
                    if (int'(r.idx) < n)
                    begin
                        if (r.kind == REQ_PUT)
                            use_mem[r.idx] = USE_FREE;
                        else
                            holds_mem[r.idx] = r.fill;
                        g.granted = 1'b1;
                        g.is_dev  = (int'(r.idx) == n - 1);
                        g.filled  = holds_mem[r.idx];
                    end
                end
                default:
                    g = '0;
            endcase
            return g;
        endfunction

        function void note_request(pool_req_t r);
            expected_grants.push_back(predict_grant(r));
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_grant(grant_t got);
            grant_t want;
            if (expected_grants.size() == 0)
            begin
                $error("result transfer with no request outstanding");
                mismatches++;
                return;
            end
            want = expected_grants.pop_front();
            compare_field("granted", want.granted, got.granted);
            compare_field("granted_entry", want.entry, got.entry);
            compare_field("is_device_buffer", want.is_dev, got.is_dev);
            compare_field("grant_tier", want.tier, got.tier);
            compare_field("entry_filled", want.filled, got.filled);
        endfunction

        function int pending();
            return expected_grants.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    // [15:0] image_tag, [16] urgent, [19:17] entry_index, [20] filled_value
    logic [23:0] s_tdata;
    // [1:0] req_type
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // [0] granted, [3:1] granted_entry, [4] is_device_buffer,
    // [6:5] grant_tier, [7] entry_filled
    logic [7:0]  m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    alloc_checker pool_chk = new();

    int unsigned burst_left = 0;
    int unsigned cur_extra = 7;
    int unsigned idle_cycles = 0;
    bit          hold_off_req = 1'b0;

    frame_buffer_pool_allocator uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    // Record every request transfer in the pool model.
    always @(posedge clk)
    begin
        pool_req_t r;
        if (rst_n && s_tvalid && s_tready)
        begin
            r.kind   = s_tuser;
            r.tag    = s_tdata[15:0];
            r.urgent = s_tdata[16];
            r.idx    = s_tdata[19:17];
            r.fill   = s_tdata[20];
            pool_chk.note_request(r);
        end
    end

    // Check every result transfer against the oldest prediction.
    always @(posedge clk)
    begin
        grant_t g;
        if (rst_n && m_tvalid && m_tready)
        begin
            g.granted = m_tdata[0];
            g.entry   = m_tdata[3:1];
            g.is_dev  = m_tdata[4];
            g.tier    = tier_t'(m_tdata[6:5]);
            g.filled  = m_tdata[7];
            pool_chk.check_grant(g);
        end
    end

    // Watchdog: end the run when no transfer happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            idle_cycles <= 0;
        else if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $error("no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_frame_buffer_pool_allocator failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Result side: a stall pattern that rotates through several duty cycles,
    // with a long hold-off whenever the stimulus asks for one.
    initial
    begin : result_sink
        int unsigned ready_tick;
        ready_tick = 0;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                ready_tick++;
                case ((ready_tick / 50) % 4)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 3) != 0);
                    2:       m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    function automatic pool_req_t mk_req(logic [1:0] kind, logic [15:0] tag, logic urgent,
                                         logic [2:0] idx, logic fill);
        pool_req_t r;
        r.kind   = kind;
        r.tag    = tag;
        r.urgent = urgent;
        r.idx    = idx;
        r.fill   = fill;
        return r;
    endfunction

    // Random request, biased toward active entries and a small set of tags
    // so that tag matches and pool exhaustion happen often.
    function automatic pool_req_t random_req(int unsigned active);
        pool_req_t   r;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            r.kind = REQ_GET;
        else if (pick < 72)
            r.kind = REQ_PUT;
        else if (pick < 95)
            r.kind = REQ_MARK;
        else
            r.kind = REQ_NONE;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            r.tag = 16'($urandom_range(0, 5));
        else if (pick == 6)
            r.tag = 16'hFFFF;
        else
            r.tag = 16'($urandom);
        r.urgent = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 85)
            r.idx = 3'($urandom_range(0, active - 1));
        else
            r.idx = 3'($urandom_range(0, 7));
        r.fill = 1'($urandom_range(0, 1));
        return r;
    endfunction

    // Offer one request and wait for its transfer; the sender works in
    // bursts of random length separated by random gaps.
    task automatic send_req(pool_req_t r);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, r.fill, r.idx, r.urgent, r.tag};
        s_tuser  <= r.kind;
        do
            @(posedge clk);
        while (!s_tready);
        burst_left--;
    endtask

    // Stop sending and wait until every result has come out and the block is idle.
    task automatic settle_pool();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pool_chk.pending() != 0)
            @(posedge clk);
        repeat (POOL_DEPTH + 6) @(posedge clk);
    endtask

    // Configuration write: setup cycle, then access cycle until pready.
    task automatic write_extra_buffers(int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_EXTRA_BUFFERS;
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        pool_chk.configure(value);
        cur_extra = value & 7;
    endtask

    initial
    begin : stimulus
        int unsigned phase_extra [NUM_PHASES];
        phase_extra = '{7, 0, 3, 1, 5, 6, 2, 4};
        phase_extra[NUM_PHASES - 1] = $urandom_range(0, 7);

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= REQ_GET;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full pool after reset: tag match on zero tags, blank grants,
        // the device buffer at the top entry, a no-op code, a double put.
        send_req(mk_req(REQ_GET,  16'h0000, 1'b0, 3'd0, 1'b0));
        send_req(mk_req(REQ_GET,  16'hFFFF, 1'b1, 3'd0, 1'b0));
        send_req(mk_req(REQ_MARK, 16'h0000, 1'b0, 3'd7, 1'b1));
        send_req(mk_req(REQ_PUT,  16'h0000, 1'b0, 3'd7, 1'b0));
        send_req(mk_req(REQ_GET,  16'hFFFF, 1'b0, 3'd0, 1'b0));
        send_req(mk_req(REQ_NONE, 16'hFFFF, 1'b1, 3'd7, 1'b1));
        send_req(mk_req(REQ_PUT,  16'h0000, 1'b0, 3'd1, 1'b0));
        send_req(mk_req(REQ_PUT,  16'h0000, 1'b0, 3'd1, 1'b0));
        settle_pool();

        // Two entries: exhaustion, refusal, forced grant, inactive entries,
        // the any-free tier that blanks a filled entry.
        write_extra_buffers(1);
        send_req(mk_req(REQ_GET,  16'hA5A5, 1'b0, 3'd0, 1'b0));
        send_req(mk_req(REQ_GET,  16'h5A5A, 1'b1, 3'd0, 1'b0));
        send_req(mk_req(REQ_GET,  16'h1111, 1'b0, 3'd0, 1'b0));
        send_req(mk_req(REQ_GET,  16'h2222, 1'b1, 3'd0, 1'b0));
        send_req(mk_req(REQ_PUT,  16'h0000, 1'b0, 3'd5, 1'b0));
        send_req(mk_req(REQ_MARK, 16'h0000, 1'b0, 3'd7, 1'b1));
        send_req(mk_req(REQ_MARK, 16'h0000, 1'b0, 3'd0, 1'b1));
        send_req(mk_req(REQ_PUT,  16'h0000, 1'b0, 3'd0, 1'b0));
        send_req(mk_req(REQ_PUT,  16'h0000, 1'b0, 3'd0, 1'b0));
        send_req(mk_req(REQ_GET,  16'h3333, 1'b1, 3'd0, 1'b0));
        send_req(mk_req(REQ_PUT,  16'h0000, 1'b0, 3'd0, 1'b0));
        send_req(mk_req(REQ_GET,  16'h3333, 1'b0, 3'd0, 1'b0));
        settle_pool();

        // Lone device buffer, which starts out in use.
        write_extra_buffers(0);
        send_req(mk_req(REQ_GET,  16'h0001, 1'b0, 3'd0, 1'b0));
        send_req(mk_req(REQ_GET,  16'hFFFF, 1'b1, 3'd0, 1'b0));
        send_req(mk_req(REQ_PUT,  16'h0000, 1'b0, 3'd0, 1'b0));
        send_req(mk_req(REQ_MARK, 16'h0000, 1'b0, 3'd0, 1'b1));
        send_req(mk_req(REQ_GET,  16'hFFFF, 1'b0, 3'd0, 1'b0));
        settle_pool();

        // Random phases, one pool size each; two of them start with a long
        // hold-off on the result side while requests keep coming.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_extra_buffers(phase_extra[p]);
            if (p == 2 || p == 5)
                hold_off_req = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_req(random_req(cur_extra + 1));
            settle_pool();
        end

        if (pool_chk.mismatches == 0)
            $display("tb_frame_buffer_pool_allocator passed");
        else
            $display("tb_frame_buffer_pool_allocator failed");
        $finish;
    end

endmodule
